// ===== rtl/vnl_pkg.sv =====
package vnl_pkg;

   localparam int COMP_W = 16;   // signed Q8.8 input component
   localparam int MAG_W  = 16;   // magnitude of a component, up to 32768
   localparam int SQR_W  = 31;   // square of one magnitude, up to 2^30
   localparam int SQ_W   = 33;   // sum of four squares, up to 2^32
   localparam int LEN_W  = 17;   // root of the squared length
   localparam int QUO_W  = 31;   // scaled ratio square, up to 2^30
   localparam int NRT_W  = 16;   // root of the scaled ratio square
   localparam int LANES  = 4;
   localparam int CSR_AW = 4;
   localparam int CSR_DW = 64;

   localparam logic [SQ_W-1:0] ONE_Q16 = SQ_W'(65536);

   // register index, taken from address bit 3
   localparam logic CSR_ZERO_THR = 1'b0;
   localparam logic CSR_UNIT_THR = 1'b1;

   typedef struct packed {
      logic [SQ_W-1:0]                   sq;
      logic                              zero;
      logic                              unit;
      logic [LANES-1:0]                  neg;
      logic [LANES-1:0][SQR_W-1:0]       sqr;
   } mid_type;

   typedef struct packed {
      logic [SQ_W-1:0]  sq;
      logic [LEN_W-1:0] root;
      logic             zero;
      logic             unit;
      logic             neg;
   } tail_type;

   typedef struct packed {
      logic signed [COMP_W-1:0] norm_x;
      logic signed [COMP_W-1:0] norm_y;
      logic signed [COMP_W-1:0] norm_z;
      logic signed [COMP_W-1:0] norm_w;
      logic [SQ_W-1:0]          length_squared;
      logic [LEN_W-1:0]         length_value;
      logic                     is_zero_flag;
      logic                     is_unit_flag;
   } rsp_type;

endpackage

// ===== rtl/vnl_isqrt.sv =====
module vnl_isqrt #(
   parameter int IN_W = 33,
   parameter int SW   = 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [IN_W-1:0]              in_rad,
   input  logic [SW-1:0]                in_side,
   output logic                         out_valid,
   output logic [(IN_W+1)/2-1:0]        out_root,
   output logic [SW-1:0]                out_side
);

   localparam int RT_W  = (IN_W + 1) / 2;
   localparam int PAD_W = 2 * RT_W;
   localparam int RM_W  = RT_W + 3;

   logic              val_w  [RT_W+1];
   logic [RM_W-1:0]   rem_w  [RT_W+1];
   logic [RT_W-1:0]   root_w [RT_W+1];
   logic [PAD_W-1:0]  rad_w  [RT_W+1];
   logic [SW-1:0]     side_w [RT_W+1];

   assign val_w[0]  = in_valid;
   assign rem_w[0]  = '0;
   assign root_w[0] = '0;
   assign rad_w[0]  = PAD_W'(in_rad);
   assign side_w[0] = in_side;

   // one result bit per stage, restoring
   for (genvar s = 0; s < RT_W; s++) begin : g_stage
      logic             val_ff;
      logic [RM_W-1:0]  rem_ff, rem_in, rem2, trial;
      logic [RT_W-1:0]  root_ff, root_in;
      logic [PAD_W-1:0] rad_ff, rad_in;
      logic [SW-1:0]    side_ff;
      logic             ge;

      always_comb begin
         rem2    = {rem_w[s][RM_W-3:0], rad_w[s][PAD_W-1 -: 2]};
         trial   = {1'b0, root_w[s], 2'b01};
         ge      = (rem2 >= trial);
         rem_in  = ge ? (rem2 - trial) : rem2;
         root_in = {root_w[s][RT_W-2:0], ge};
         rad_in  = {rad_w[s][PAD_W-3:0], 2'b00};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            val_ff <= 1'b0;
         end else if (en) begin
            val_ff <= val_w[s];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff  <= rem_in;
            root_ff <= root_in;
            rad_ff  <= rad_in;
            side_ff <= side_w[s];
         end
      end

      assign val_w[s+1]  = val_ff;
      assign rem_w[s+1]  = rem_ff;
      assign root_w[s+1] = root_ff;
      assign rad_w[s+1]  = rad_ff;
      assign side_w[s+1] = side_ff;
   end

   assign out_valid = val_w[RT_W];
   assign out_root  = root_w[RT_W];
   assign out_side  = side_w[RT_W];

endmodule

// ===== rtl/vnl_div.sv =====
module vnl_div #(
   parameter int QW = 31,
   parameter int DW = 33,
   parameter int SW = 1
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           en,
   input  logic           in_valid,
   input  logic [DW-1:0]  in_rem,
   input  logic [QW-1:0]  in_low,
   input  logic [DW-1:0]  in_den,
   input  logic [SW-1:0]  in_side,
   output logic           out_valid,
   output logic [QW-1:0]  out_quo,
   output logic [SW-1:0]  out_side
);

   logic           val_w  [QW+1];
   logic [DW-1:0]  rem_w  [QW+1];
   logic [QW-1:0]  low_w  [QW+1];
   logic [DW-1:0]  den_w  [QW+1];
   logic [QW-1:0]  quo_w  [QW+1];
   logic [SW-1:0]  side_w [QW+1];

   assign val_w[0]  = in_valid;
   assign rem_w[0]  = in_rem;
   assign low_w[0]  = in_low;
   assign den_w[0]  = in_den;
   assign quo_w[0]  = '0;
   assign side_w[0] = in_side;

   // one quotient bit per stage; partial remainder stays below the divisor
   for (genvar s = 0; s < QW; s++) begin : g_stage
      logic           val_ff;
      logic [DW:0]    r2, diff;
      logic           ge;
      logic [DW-1:0]  rem_ff, rem_in, den_ff;
      logic [QW-1:0]  low_ff, low_in, quo_ff, quo_in;
      logic [SW-1:0]  side_ff;

      always_comb begin
         r2     = {rem_w[s], low_w[s][QW-1]};
         diff   = r2 - {1'b0, den_w[s]};
         ge     = (r2 >= {1'b0, den_w[s]});
         rem_in = ge ? diff[DW-1:0] : r2[DW-1:0];
         quo_in = {quo_w[s][QW-2:0], ge};
         low_in = {low_w[s][QW-2:0], 1'b0};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            val_ff <= 1'b0;
         end else if (en) begin
            val_ff <= val_w[s];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff  <= rem_in;
            low_ff  <= low_in;
            den_ff  <= den_w[s];
            quo_ff  <= quo_in;
            side_ff <= side_w[s];
         end
      end

      assign val_w[s+1]  = val_ff;
      assign rem_w[s+1]  = rem_ff;
      assign low_w[s+1]  = low_ff;
      assign den_w[s+1]  = den_ff;
      assign quo_w[s+1]  = quo_ff;
      assign side_w[s+1] = side_ff;
   end

   assign out_valid = val_w[QW];
   assign out_quo   = quo_w[QW];
   assign out_side  = side_w[QW];

endmodule

// ===== rtl/vector4_normalize_length_core.sv =====
// A request word passes through 4 front stages, 17 length-root stages,
// 31 divider stages and 16 lane-root stages into the output queue. Throughput: one word
// per cycle while req_stall is low; a two-entry output queue lets the pipeline keep
// taking words while a result waits, and req_stall rises only when both entries are full.
// Reset (synchronous): clears all valid bits and the output queue, sets both thresholds to 1.
module vector4_normalize_length_core (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [vnl_pkg::COMP_W-1:0]  req_comp_x,
   input  logic signed [vnl_pkg::COMP_W-1:0]  req_comp_y,
   input  logic signed [vnl_pkg::COMP_W-1:0]  req_comp_z,
   input  logic signed [vnl_pkg::COMP_W-1:0]  req_comp_w,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [vnl_pkg::COMP_W-1:0]  rsp_norm_x,
   output logic signed [vnl_pkg::COMP_W-1:0]  rsp_norm_y,
   output logic signed [vnl_pkg::COMP_W-1:0]  rsp_norm_z,
   output logic signed [vnl_pkg::COMP_W-1:0]  rsp_norm_w,
   output logic [vnl_pkg::SQ_W-1:0]           rsp_length_squared,
   output logic [vnl_pkg::LEN_W-1:0]          rsp_length_value,
   output logic                               rsp_is_zero_flag,
   output logic                               rsp_is_unit_flag,
   // configuration port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [vnl_pkg::CSR_AW-1:0]         csr_paddr,
   input  logic [vnl_pkg::CSR_DW-1:0]         csr_pwdata,
   output logic [vnl_pkg::CSR_DW-1:0]         csr_prdata,
   output logic                               csr_pready
);

   localparam int LANES = vnl_pkg::LANES;
   localparam int SQ_W  = vnl_pkg::SQ_W;
   localparam int SQR_W = vnl_pkg::SQR_W;
   localparam int MAG_W = vnl_pkg::MAG_W;

   // ---------------------------------------------------------------------
   // Threshold registers. Write only while the pipeline is empty; not enforced here.
   // ---------------------------------------------------------------------
   logic [SQ_W-1:0] zero_thr_ff, unit_thr_ff;
   logic            csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_thr_ff <= SQ_W'(1);
         unit_thr_ff <= SQ_W'(1);
      end else if (csr_wr) begin
         if (csr_paddr[3] == vnl_pkg::CSR_ZERO_THR) begin
            zero_thr_ff <= csr_pwdata[SQ_W-1:0];
         end else begin
            unit_thr_ff <= csr_pwdata[SQ_W-1:0];
         end
      end
   end

   assign csr_prdata = (csr_paddr[3] == vnl_pkg::CSR_UNIT_THR)
                       ? vnl_pkg::CSR_DW'(unit_thr_ff)
                       : vnl_pkg::CSR_DW'(zero_thr_ff);

   // ---------------------------------------------------------------------
   // Pipeline enable: every stage moves together as long as the output
   // queue has a free entry for whatever leaves the last stage.
   // ---------------------------------------------------------------------
   logic [1:0] cnt_ff, cnt_in;
   logic       en;

   assign en        = (cnt_ff != 2'd2);
   assign req_stall = ~en;

   // ---------------------------------------------------------------------
   // Stage 1: split each component into magnitude and sign.
   // ---------------------------------------------------------------------
   logic [LANES-1:0][vnl_pkg::COMP_W-1:0] comp;
   logic                                  s1_valid_ff;
   logic [LANES-1:0][MAG_W-1:0]           s1_mag_ff, s1_mag_in;
   logic [LANES-1:0]                      s1_neg_ff, s1_neg_in;

   assign comp = {req_comp_w, req_comp_z, req_comp_y, req_comp_x};

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         s1_neg_in[i] = comp[i][vnl_pkg::COMP_W-1];
         s1_mag_in[i] = s1_neg_in[i] ? MAG_W'(~comp[i] + 1'b1) : MAG_W'(comp[i]);
      end
   end

   // Stage 2: square each magnitude.
   logic                          s2_valid_ff;
   logic [LANES-1:0][SQR_W-1:0]   s2_sqr_ff, s2_sqr_in;
   logic [LANES-1:0]              s2_neg_ff;

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         s2_sqr_in[i] = SQR_W'(s1_mag_ff[i]) * SQR_W'(s1_mag_ff[i]);
      end
   end

   // Stage 3: add the four squares.
   logic                          s3_valid_ff;
   logic [SQ_W-1:0]               s3_sq_ff, s3_sq_in;
   logic [LANES-1:0][SQR_W-1:0]   s3_sqr_ff;
   logic [LANES-1:0]              s3_neg_ff;

   assign s3_sq_in = (SQ_W'(s2_sqr_ff[0]) + SQ_W'(s2_sqr_ff[1]))
                   + (SQ_W'(s2_sqr_ff[2]) + SQ_W'(s2_sqr_ff[3]));

   // Stage 4: compare against both thresholds.
   logic              s4_valid_ff;
   vnl_pkg::mid_type  s4_mid_ff, s4_mid_in;
   logic [SQ_W-1:0]   unit_gap;

   always_comb begin
      unit_gap = (s3_sq_ff > vnl_pkg::ONE_Q16) ? (s3_sq_ff - vnl_pkg::ONE_Q16)
                                               : (vnl_pkg::ONE_Q16 - s3_sq_ff);
      s4_mid_in.sq   = s3_sq_ff;
      s4_mid_in.zero = (s3_sq_ff < zero_thr_ff);
      s4_mid_in.unit = (unit_gap < unit_thr_ff);
      s4_mid_in.neg  = s3_neg_ff;
      s4_mid_in.sqr  = s3_sqr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_mag_ff <= s1_mag_in;
         s1_neg_ff <= s1_neg_in;
         s2_sqr_ff <= s2_sqr_in;
         s2_neg_ff <= s1_neg_ff;
         s3_sq_ff  <= s3_sq_in;
         s3_sqr_ff <= s2_sqr_ff;
         s3_neg_ff <= s2_neg_ff;
         s4_mid_ff <= s4_mid_in;
      end
   end

   // ---------------------------------------------------------------------
   // Length: floor root of the squared length, carrying the rest alongside.
   // ---------------------------------------------------------------------
   logic                       len_valid;
   logic [vnl_pkg::LEN_W-1:0]  len_root;
   logic [$bits(vnl_pkg::mid_type)-1:0] len_side;
   vnl_pkg::mid_type           len_mid;

   vnl_isqrt #(
      .IN_W (SQ_W),
      .SW   ($bits(vnl_pkg::mid_type))
   ) u_len_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s4_valid_ff),
      .in_rad    (s4_mid_ff.sq),
      .in_side   (s4_mid_ff),
      .out_valid (len_valid),
      .out_root  (len_root),
      .out_side  (len_side)
   );

   assign len_mid = vnl_pkg::mid_type'(len_side);

   // ---------------------------------------------------------------------
   // Lanes: the rounded result is (isqrt(floor(sqr * 2^30 / sq)) + 1) / 2,
   // which is the nearest Q1.14 value of mag / length with ties going up.
   // The quotient stays at or below 2^30 since one square never exceeds the sum.
   // ---------------------------------------------------------------------
   vnl_pkg::tail_type                 lane0_tail_in, tail;
   logic [$bits(vnl_pkg::tail_type)-1:0] tail_side;
   logic [LANES-1:0]                  lane_valid;
   logic [LANES-1:0]                  lane_neg;
   logic [LANES-1:0][vnl_pkg::NRT_W-1:0] lane_root;

   always_comb begin
      lane0_tail_in.sq   = len_mid.sq;
      lane0_tail_in.root = len_root;
      lane0_tail_in.zero = len_mid.zero;
      lane0_tail_in.unit = len_mid.unit;
      lane0_tail_in.neg  = len_mid.neg[0];
   end

   for (genvar gi = 0; gi < LANES; gi++) begin : g_lane
      logic [SQ_W-1:0]           div_rem0;
      logic [vnl_pkg::QUO_W-1:0] div_low;
      logic                      div_valid;
      logic [vnl_pkg::QUO_W-1:0] div_quo;

      assign div_rem0 = SQ_W'(len_mid.sqr[gi][SQR_W-1:1]);
      assign div_low  = {len_mid.sqr[gi][0], (vnl_pkg::QUO_W-1)'(0)};

      if (gi == 0) begin : g_head
         logic [$bits(vnl_pkg::tail_type)-1:0] div_side;

         vnl_div #(
            .QW (vnl_pkg::QUO_W),
            .DW (SQ_W),
            .SW ($bits(vnl_pkg::tail_type))
         ) u_div (
            .clock     (clock),
            .reset     (reset),
            .en        (en),
            .in_valid  (len_valid),
            .in_rem    (div_rem0),
            .in_low    (div_low),
            .in_den    (len_mid.sq),
            .in_side   (lane0_tail_in),
            .out_valid (div_valid),
            .out_quo   (div_quo),
            .out_side  (div_side)
         );

         vnl_isqrt #(
            .IN_W (vnl_pkg::QUO_W),
            .SW   ($bits(vnl_pkg::tail_type))
         ) u_sqrt (
            .clock     (clock),
            .reset     (reset),
            .en        (en),
            .in_valid  (div_valid),
            .in_rad    (div_quo),
            .in_side   (div_side),
            .out_valid (lane_valid[gi]),
            .out_root  (lane_root[gi]),
            .out_side  (tail_side)
         );

         assign tail         = vnl_pkg::tail_type'(tail_side);
         assign lane_neg[gi] = tail.neg;
      end else begin : g_body
         logic div_neg;

         vnl_div #(
            .QW (vnl_pkg::QUO_W),
            .DW (SQ_W),
            .SW (1)
         ) u_div (
            .clock     (clock),
            .reset     (reset),
            .en        (en),
            .in_valid  (len_valid),
            .in_rem    (div_rem0),
            .in_low    (div_low),
            .in_den    (len_mid.sq),
            .in_side   (len_mid.neg[gi]),
            .out_valid (div_valid),
            .out_quo   (div_quo),
            .out_side  (div_neg)
         );

         vnl_isqrt #(
            .IN_W (vnl_pkg::QUO_W),
            .SW   (1)
         ) u_sqrt (
            .clock     (clock),
            .reset     (reset),
            .en        (en),
            .in_valid  (div_valid),
            .in_rad    (div_quo),
            .in_side   (div_neg),
            .out_valid (lane_valid[gi]),
            .out_root  (lane_root[gi]),
            .out_side  (lane_neg[gi])
         );
      end
   end

   // ---------------------------------------------------------------------
   // Assemble the result word: halve with rounding, drop for zero vectors,
   // then restore the sign.
   // ---------------------------------------------------------------------
   vnl_pkg::rsp_type                      new_word;
   logic [LANES-1:0][vnl_pkg::COMP_W-1:0] nrm;
   logic                                  kill;

   always_comb begin
      logic [vnl_pkg::NRT_W:0] half;
      kill = tail.zero | (tail.sq == '0);
      for (int i = 0; i < LANES; i++) begin
         half   = ((vnl_pkg::NRT_W+1)'(lane_root[i]) + 1'b1) >> 1;
         nrm[i] = kill ? '0
                : (lane_neg[i] ? vnl_pkg::COMP_W'(~half + 1'b1) : vnl_pkg::COMP_W'(half));
      end
      new_word.norm_x         = nrm[0];
      new_word.norm_y         = nrm[1];
      new_word.norm_z         = nrm[2];
      new_word.norm_w         = nrm[3];
      new_word.length_squared = tail.sq;
      new_word.length_value   = tail.root;
      new_word.is_zero_flag   = tail.zero;
      new_word.is_unit_flag   = tail.unit;
   end

   // ---------------------------------------------------------------------
   // Two-entry output queue: head drives the response ports.
   // ---------------------------------------------------------------------
   vnl_pkg::rsp_type head_ff, head_in, spare_ff, spare_in;
   logic             push, pop;

   assign push = en & lane_valid[0];
   assign pop  = rsp_valid & ~rsp_stall;

   always_comb begin
      head_in  = head_ff;
      spare_in = spare_ff;
      cnt_in   = cnt_ff;
      case ({push, pop})
         2'b11: begin
            if (cnt_ff == 2'd1) begin
               head_in = new_word;
            end else begin
               head_in  = spare_ff;
               spare_in = new_word;
            end
         end
         2'b01: begin
            head_in = spare_ff;
            cnt_in  = cnt_ff - 2'd1;
         end
         2'b10: begin
            if (cnt_ff == 2'd0) begin
               head_in = new_word;
            end else begin
               spare_in = new_word;
            end
            cnt_in = cnt_ff + 2'd1;
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff  <= head_in;
      spare_ff <= spare_in;
   end

   assign rsp_valid          = (cnt_ff != 2'd0);
   assign rsp_norm_x         = head_ff.norm_x;
   assign rsp_norm_y         = head_ff.norm_y;
   assign rsp_norm_z         = head_ff.norm_z;
   assign rsp_norm_w         = head_ff.norm_w;
   assign rsp_length_squared = head_ff.length_squared;
   assign rsp_length_value   = head_ff.length_value;
   assign rsp_is_zero_flag   = head_ff.is_zero_flag;
   assign rsp_is_unit_flag   = head_ff.is_unit_flag;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("output queue count out of range");

   a_zero_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_zero_flag) |->
      (rsp_norm_x == '0 && rsp_norm_y == '0 && rsp_norm_z == '0 && rsp_norm_w == '0))
      else $error("zero vector with nonzero normalized output");

   a_root_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
      (36'(rsp_length_value) * 36'(rsp_length_value) <= 36'(rsp_length_squared)))
      else $error("length exceeds root of squared length");

   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2 && rsp_stall) |=> (cnt_ff == 2'd2))
      else $error("queue lost a word while stalled");

endmodule

// ===== bench/vector4_normalize_length_core_test.sv =====
`timescale 1ns / 100ps

// Result checker: holds the thresholds and the queue of predicted results.
class norm_scoreboard;
   vnl_pkg::rsp_type pending[$];
   logic [32:0]      zero_thr;
   logic [32:0]      unit_thr;
   int               fail_count;
   int               checked;

   function new();
      zero_thr = 33'd1;
      unit_thr = 33'd1;
      fail_count = 0;
      checked = 0;
   endfunction

   // integer square root, floor
   function automatic logic [63:0] int_root(logic [63:0] n);
      logic [63:0] root;
      logic [63:0] bits;
      root = 0;
      bits = 64'd1 << 32;
      while (bits > n) bits = bits >> 2;
      while (bits != 0) begin
         if (n >= root + bits) begin
            n = n - (root + bits);
            root = (root >> 1) + bits;
         end else begin
            root = root >> 1;
         end
         bits = bits >> 2;
      end
      return root;
   endfunction

   // round(mag * 16384 / sqrt(sq)) with ties away from zero, capped at 16384
   function automatic logic [63:0] lane_mag(logic [63:0] mag, logic [63:0] sq);
      logic [63:0] target;
      logic [63:0] q;
      logic [63:0] trial;
      logic [63:0] odd;
      logic [63:0] step;
      target = (mag * 32768) * (mag * 32768);
      q = 0;
      step = 16384;
      while (step != 0) begin
         trial = q | step;
         if (trial <= 16384) begin
            odd = 2 * trial - 1;
            if (odd * odd * sq <= target) q = trial;
         end
         step = step >> 1;
      end
      return q;
   endfunction

   // note an accepted word: predict its result
   function void note_vector(logic signed [15:0] c[4]);
      vnl_pkg::rsp_type r;
      logic [63:0] mag[4];
      logic [63:0] sq;
      logic [63:0] unit_gap;
      logic [63:0] n;
      logic [15:0] lane[4];
      sq = 0;
      for (int i = 0; i < 4; i++) begin
         mag[i] = c[i] < 0 ? 64'(-32'(c[i])) : 64'(c[i]);
         sq = sq + mag[i] * mag[i];
      end
      r.is_zero_flag = sq < {31'd0, zero_thr};
      unit_gap = sq > 65536 ? sq - 65536 : 65536 - sq;
      r.is_unit_flag = unit_gap < {31'd0, unit_thr};
      for (int i = 0; i < 4; i++) begin
         n = 0;
         if (!r.is_zero_flag && sq != 0) n = lane_mag(mag[i], sq);
         if (c[i] < 0 && n != 0) n = 64'h10000 - n;
         lane[i] = n[15:0];
      end
      r.norm_x = lane[0];
      r.norm_y = lane[1];
      r.norm_z = lane[2];
      r.norm_w = lane[3];
      r.length_squared = sq[32:0];
      r.length_value = 17'(int_root(sq));
      pending.push_back(r);
   endfunction

   task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h (result %0d)", what, got, want, checked);
      fail_count++;
   endtask

   task check_result(vnl_pkg::rsp_type got);
      vnl_pkg::rsp_type want;
      if (pending.size() == 0) begin
         report("unexpected result word", 64'(got.length_squared), 64'd0);
         checked++;
         return;
      end
      want = pending.pop_front();
      if (got.norm_x !== want.norm_x) report("norm_x", 64'(got.norm_x), 64'(want.norm_x));
      if (got.norm_y !== want.norm_y) report("norm_y", 64'(got.norm_y), 64'(want.norm_y));
      if (got.norm_z !== want.norm_z) report("norm_z", 64'(got.norm_z), 64'(want.norm_z));
      if (got.norm_w !== want.norm_w) report("norm_w", 64'(got.norm_w), 64'(want.norm_w));
      if (got.length_squared !== want.length_squared)
         report("length_squared", 64'(got.length_squared), 64'(want.length_squared));
      if (got.length_value !== want.length_value)
         report("length_value", 64'(got.length_value), 64'(want.length_value));
      if (got.is_zero_flag !== want.is_zero_flag)
         report("is_zero_flag", 64'(got.is_zero_flag), 64'(want.is_zero_flag));
      if (got.is_unit_flag !== want.is_unit_flag)
         report("is_unit_flag", 64'(got.is_unit_flag), 64'(want.is_unit_flag));
      checked++;
   endtask
endclass

module vector4_normalize_length_core_test;

   localparam int LATENCY   = 68;
   localparam int MAX_CYCLE = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic signed [vnl_pkg::COMP_W-1:0] req_comp_x = '0;
   logic signed [vnl_pkg::COMP_W-1:0] req_comp_y = '0;
   logic signed [vnl_pkg::COMP_W-1:0] req_comp_z = '0;
   logic signed [vnl_pkg::COMP_W-1:0] req_comp_w = '0;

   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic signed [vnl_pkg::COMP_W-1:0] rsp_norm_x;
   logic signed [vnl_pkg::COMP_W-1:0] rsp_norm_y;
   logic signed [vnl_pkg::COMP_W-1:0] rsp_norm_z;
   logic signed [vnl_pkg::COMP_W-1:0] rsp_norm_w;
   logic [vnl_pkg::SQ_W-1:0]          rsp_length_squared;
   logic [vnl_pkg::LEN_W-1:0]         rsp_length_value;
   logic                              rsp_is_zero_flag;
   logic                              rsp_is_unit_flag;

   logic                              csr_psel = 1'b0;
   logic                              csr_penable = 1'b0;
   logic                              csr_pwrite = 1'b0;
   logic [vnl_pkg::CSR_AW-1:0]        csr_paddr = '0;
   logic [vnl_pkg::CSR_DW-1:0]        csr_pwdata = '0;
   logic [vnl_pkg::CSR_DW-1:0]        csr_prdata;
   logic                              csr_pready;

   norm_scoreboard board = new();

   int  cycle = 0;
   bit  idle_on = 1'b1;   // drop to end the random idling near the close of the run
   int  sent = 0;

   always #5 clock = ~clock;

   vector4_normalize_length_core u_dut (.*);

   // Count cycles; stop a hung run.
   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle > MAX_CYCLE) begin
         $display("timeout after %0d cycles, %0d words outstanding", cycle,
                  board.pending.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // Result side: sample accepted words and drive stall in random bursts.
   int stall_left = 0;
   always @(posedge clock) begin
      vnl_pkg::rsp_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.norm_x = rsp_norm_x;
         got.norm_y = rsp_norm_y;
         got.norm_z = rsp_norm_z;
         got.norm_w = rsp_norm_w;
         got.length_squared = rsp_length_squared;
         got.length_value = rsp_length_value;
         got.is_zero_flag = rsp_is_zero_flag;
         got.is_unit_flag = rsp_is_unit_flag;
         board.check_result(got);
      end
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 14);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Write one register through the two-phase bus cycle.
   task automatic csr_write(logic sel, logic [32:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {sel, 3'b000};
      csr_pwdata <= {31'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (sel == vnl_pkg::CSR_ZERO_THR) board.zero_thr = value;
      else board.unit_thr = value;
   endtask

   // Present one word, hold it until accepted; sometimes a random gap first.
   task automatic send_vector(logic signed [15:0] x, logic signed [15:0] y,
                              logic signed [15:0] z, logic signed [15:0] w);
      logic signed [15:0] c[4];
      int gap;
      c = '{x, y, z, w};
      if (idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 15);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_comp_x <= x;
      req_comp_y <= y;
      req_comp_z <= z;
      req_comp_w <= w;
      do @(posedge clock); while (req_stall);
      board.note_vector(c);
      sent++;
   endtask

   task automatic release_request();
      req_valid <= 1'b0;
   endtask

   // Drain all predicted words, then let the pipeline settle.
   task automatic drain();
      int waited;
      release_request();
      waited = 0;
      while (board.pending.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic logic signed [15:0] rand_comp(int mode);
      case (mode)
         0: return 16'($urandom);
         1: return 16'($signed($urandom_range(0, 512)) - 256);   // each component within +-1.0
         2: return 16'($signed($urandom_range(0, 8)) - 4);       // tiny
         default: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      endcase
   endfunction

   task automatic random_phase(int count);
      int mode;
      for (int i = 0; i < count; i++) begin
         mode = $urandom_range(0, 9) < 5 ? 0 : $urandom_range(1, 3);
         send_vector(rand_comp(mode), rand_comp(mode), rand_comp(mode), rand_comp(mode));
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words at reset thresholds: extremes, zero vector, unit axes.
      send_vector(0, 0, 0, 0);
      send_vector(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      send_vector(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
      send_vector(16'sh8000, 0, 0, 0);
      send_vector(0, 16'sh7FFF, 0, 0);
      send_vector(256, 0, 0, 0);
      send_vector(0, 0, -256, 0);
      send_vector(0, 0, 0, 1);
      send_vector(-1, 1, -1, 1);
      send_vector(128, 128, 128, 128);
      send_vector(3, -4, 0, 0);
      send_vector(16'sh5555, 16'shAAAA, 16'sh0F0F, 16'shF0F0);
      drain();

      // Zero threshold 0: the empty vector must still give zero lanes.
      csr_write(vnl_pkg::CSR_ZERO_THR, 33'd0);
      csr_write(vnl_pkg::CSR_UNIT_THR, 33'h1_0000_0000);
      send_vector(0, 0, 0, 0);
      send_vector(1, 0, 0, 0);
      send_vector(256, 0, 0, 0);
      random_phase(120);
      drain();

      // Zero threshold 2^32: all but a squared length of 2^32 count as zero.
      csr_write(vnl_pkg::CSR_ZERO_THR, 33'h1_0000_0000);
      csr_write(vnl_pkg::CSR_UNIT_THR, 33'd0);
      send_vector(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
      send_vector(16'sh7FFF, 0, 0, 0);
      random_phase(100);
      drain();

      // Moderate thresholds around unit length.
      csr_write(vnl_pkg::CSR_ZERO_THR, 33'd65536);
      csr_write(vnl_pkg::CSR_UNIT_THR, 33'd4096);
      random_phase(150);
      drain();

      // Random thresholds, then no idling at the close.
      csr_write(vnl_pkg::CSR_ZERO_THR, {1'($urandom_range(0, 1)), $urandom});
      csr_write(vnl_pkg::CSR_UNIT_THR, 33'($urandom_range(0, 200000)));
      random_phase(100);
      idle_on = 1'b0;
      random_phase(60);
      drain();

      $display("Covered %0d vectors across five threshold settings, %0d results checked.",
               sent, board.checked);
      if (board.fail_count == 0 && board.pending.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
rtl/vnl_pkg.sv
rtl/vnl_isqrt.sv
rtl/vnl_div.sv
rtl/vector4_normalize_length_core.sv
bench/vector4_normalize_length_core_test.sv
